// ----- design/srsw_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srsw_pkg
// Shared types, codes and defaults of the selective repeat sender window.
// ---------------------------------------------------------------------------
package srsw_pkg;

    localparam int MAX_WINDOW_DEF  = 8;
    localparam int SEQ_BITS_DEF    = 16;
    localparam int HANDLE_BITS_DEF = 16;

    // apb register map, one 32-bit word per register
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [3:0] WIN_LIMIT_RESET     = 4'd5;
    localparam logic [7:0] TIMEOUT_TICKS_RESET = 8'd10;
    localparam logic [7:0] AGE_MAX             = 8'd255;

    typedef enum logic [0:0] {
        REG_WIN_LIMIT     = 1'b0,
        REG_TIMEOUT_TICKS = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_SEND = 2'd0,
        OP_ACK  = 2'd1,
        OP_TICK = 2'd2,
        OP_END  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_NEW     = 2'd0,
        KIND_RETX    = 2'd1,
        KIND_REFUSED = 2'd2,
        KIND_STATUS  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEND,
        ST_ACK,
        ST_SLIDE,
        ST_SCAN_RD,
        ST_SCAN_UPD,
        ST_RETX,
        ST_STATUS
    } state_t;

    typedef enum logic [1:0] {
        ALU_NEXT_INC,
        ALU_ACK_DIST,
        ALU_BASE_INC,
        ALU_RETX_SEQ
    } alu_sel_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] handle;
        logic [15:0] ack_seq;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] seq;
        logic [15:0] buffer_handle;
        logic [15:0] base_seq;
        logic [3:0]  outstanding;
        logic        done_res;
        logic        last;
    } out_item_t;

    // datapath conditions seen by the sequencer
    typedef struct packed {
        logic accept;
        op_t  op;
        logic window_empty;
        logic ack_mark;
        logic slide_go;
        logic timed_out;
        logic scan_last;
        logic out_free;
    } srsw_stat_t;

    // sequencer commands to the datapath
    typedef struct packed {
        logic     ready;
        logic     load_send;
        logic     mark_ack;
        logic     slide;
        logic     age_upd;
        logic     advance;
        logic     load_retx;
        logic     load_status;
        logic     scan_start;
        alu_sel_t alu_sel;
    } srsw_ctrl_t;

endpackage

// ----- design/srsw_slot_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srsw_slot_ram
// Per-slot storage, one write port and one registered read port.
// ---------------------------------------------------------------------------
module srsw_slot_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 16,
    parameter int AW    = 3
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/srsw_seq_alu.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srsw_seq_alu
// Shared modular add/subtract on sequence numbers.
// ---------------------------------------------------------------------------
module srsw_seq_alu
    import srsw_pkg::*;
#(
    parameter int SEQ_BITS = SEQ_BITS_DEF
) (
    input  alu_sel_t            sel,
    input  logic [SEQ_BITS-1:0] base_seq,
    input  logic [SEQ_BITS-1:0] next_seq,
    input  logic [SEQ_BITS-1:0] ack_seq,
    input  logic [SEQ_BITS-1:0] offset,
    output logic [SEQ_BITS-1:0] result
);

    logic [SEQ_BITS-1:0] op_a;
    logic [SEQ_BITS-1:0] op_b;
    logic                sub;

    always_comb begin
        op_a = base_seq;
        op_b = SEQ_BITS'(1);
        sub  = 1'b0;
        unique case (sel)
            ALU_NEXT_INC: begin
                op_a = next_seq;
            end
            ALU_ACK_DIST: begin
                op_a = ack_seq;
                op_b = base_seq;
                sub  = 1'b1;
            end
            ALU_BASE_INC: begin
                op_a = base_seq;
            end
            ALU_RETX_SEQ: begin
                op_b = offset;
            end
            default: begin
                op_a = base_seq;
            end
        endcase
    end

    // one adder, subtract by inverting b and carrying in
    assign result = op_a + (sub ? ~op_b : op_b) + SEQ_BITS'(sub);

endmodule

// ----- design/srsw_fsm.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srsw_fsm
// Sequencer: walks send, ack/slide and tick scans one step per cycle, holding while the result output is busy.
// ---------------------------------------------------------------------------
module srsw_fsm
    import srsw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  srsw_stat_t stat,
    output srsw_ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (stat.accept) begin
                    unique case (stat.op)
                        OP_SEND: state_next = ST_SEND;
                        OP_ACK:  state_next = ST_ACK;
                        OP_TICK: state_next = stat.window_empty ? ST_STATUS : ST_SCAN_RD;
                        OP_END:  state_next = ST_STATUS;
                        default: state_next = ST_STATUS;
                    endcase
                end
            end
            ST_SEND: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            ST_ACK: begin
                state_next = stat.ack_mark ? ST_SLIDE : ST_STATUS;
            end
            ST_SLIDE: begin
                if (!stat.slide_go) state_next = ST_STATUS;
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_UPD;
            end
            ST_SCAN_UPD: begin
                if (stat.timed_out) begin
                    state_next = ST_RETX;
                end else begin
                    state_next = stat.scan_last ? ST_STATUS : ST_SCAN_RD;
                end
            end
            ST_RETX: begin
                if (stat.out_free) begin
                    state_next = stat.scan_last ? ST_STATUS : ST_SCAN_RD;
                end
            end
            ST_STATUS: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl             = '0;
        ctrl.alu_sel     = ALU_BASE_INC;
        ctrl.ready       = (state_reg == ST_IDLE);
        ctrl.scan_start  = (state_reg == ST_IDLE) && stat.accept && (stat.op == OP_TICK);
        ctrl.load_send   = (state_reg == ST_SEND) && stat.out_free;
        ctrl.mark_ack    = (state_reg == ST_ACK) && stat.ack_mark;
        ctrl.slide       = (state_reg == ST_SLIDE) && stat.slide_go;
        ctrl.age_upd     = (state_reg == ST_SCAN_UPD);
        ctrl.advance     = ((state_reg == ST_SCAN_UPD) && !stat.timed_out) ||
                           ((state_reg == ST_RETX) && stat.out_free);
        ctrl.load_retx   = (state_reg == ST_RETX) && stat.out_free;
        ctrl.load_status = (state_reg == ST_STATUS) && stat.out_free;
        unique case (state_reg)
            ST_SEND: ctrl.alu_sel = ALU_NEXT_INC;
            ST_ACK:  ctrl.alu_sel = ALU_ACK_DIST;
            ST_RETX: ctrl.alu_sel = ALU_RETX_SEQ;
            default: ctrl.alu_sel = ALU_BASE_INC;
        endcase
    end

endmodule

// ----- design/selective_repeat_sender_window.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// selective_repeat_sender_window
// Sender side of selective repeat ARQ: window slots, ack slide, tick timeouts.
// ---------------------------------------------------------------------------
// latency, accept edge to result valid, follows the states: send loads in SEND,
//   end in STATUS; ack runs ACK, SLIDE per acked base slot, STATUS; tick runs
//   STATUS if empty, else SCAN_RD, SCAN_UPD per slot, RETX per timeout, STATUS
// one request at a time; next taken in the cycle after the last result loads;
//   a stalled result adds its wait; one sequence adder and one slot port shared
// reset (synchronous, aresetn low): window empty, base and next at 0,
//   window limit 5, timeout_ticks 10; slot buffers and ages are not cleared
module selective_repeat_sender_window
    import srsw_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SEQ_BITS    = SEQ_BITS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int SW = $clog2(MAX_WINDOW);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    // window cap from the slot count and half the sequence space
    localparam int WIN_CAP = (SEQ_BITS - 1 >= 7) ? MAX_WINDOW :
                             ((MAX_WINDOW < (1 << (SEQ_BITS - 1))) ? MAX_WINDOW :
                              (1 << (SEQ_BITS - 1)));

    logic [3:0]             win_size_reg;
    logic [7:0]             timeout_reg;
    logic [SEQ_BITS-1:0]    base_reg;
    logic [SEQ_BITS-1:0]    next_reg;
    logic [CW-1:0]          cnt_reg;
    logic [SW-1:0]          base_slot_reg;
    logic [SW-1:0]          ptr_reg;
    logic [CW-1:0]          idx_reg;
    logic [MAX_WINDOW-1:0]  in_use_reg;
    logic [MAX_WINDOW-1:0]  acked_reg;
    logic                   finished_reg;
    logic [HANDLE_BITS-1:0] hnd_reg;
    logic [SEQ_BITS-1:0]    ack_reg;
    out_item_t              out_reg;
    logic                   m_valid_reg;

    srsw_stat_t             stat;
    srsw_ctrl_t             ctrl;
    logic                   accept;
    logic                   out_free;
    logic                   cfg_wr;
    logic                   done_now;
    logic                   send_ok;
    logic [SEQ_BITS-1:0]    alu_res;
    logic [SW:0]            slot_off;
    logic [SW:0]            slot_sum;
    logic [SW-1:0]          slot_sel;
    logic                   ack_hit;
    logic [SW-1:0]          base_slot_next;
    logic [SW-1:0]          ptr_next;
    logic [HANDLE_BITS-1:0] buf_rd;
    logic [7:0]             age_rd;
    logic [7:0]             age_inc;
    logic                   slot_live;
    logic                   age_wr_en;
    logic [SW-1:0]          age_wr_addr;
    logic [7:0]             age_wr_data;
    logic                   buf_wr_en;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign done_now = finished_reg && (cnt_reg == '0);
    assign send_ok  = !finished_reg && (8'(cnt_reg) < 8'(win_size_reg)) &&
                      (8'(cnt_reg) < 8'(WIN_CAP));

    // ---------------- config port ----------------
    assign pready = 1'b1;

    always_comb begin
        unique case (reg_idx_t'(paddr[2]))
            REG_WIN_LIMIT:     prdata = APB_DATA_W'(win_size_reg);
            REG_TIMEOUT_TICKS: prdata = APB_DATA_W'(timeout_reg);
            default:           prdata = '0;
        endcase
    end

    // ---------------- sequencer and shared adder ----------------
    srsw_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    assign s_ready = ctrl.ready;

    srsw_seq_alu #(
        .SEQ_BITS (SEQ_BITS)
    ) u_alu (
        .sel      (ctrl.alu_sel),
        .base_seq (base_reg),
        .next_seq (next_reg),
        .ack_seq  (ack_reg),
        .offset   (SEQ_BITS'(idx_reg)),
        .result   (alu_res)
    );

    // slot of base + offset; offset is the fill count on send, else the adder result (the ack distance on ack)
    assign ack_hit  = alu_res < SEQ_BITS'(cnt_reg);
    assign slot_off = ctrl.load_send ? (SW+1)'(cnt_reg) : (SW+1)'(alu_res);
    assign slot_sum = (SW+1)'(base_slot_reg) + slot_off;
    assign slot_sel = (slot_sum >= (SW+1)'(MAX_WINDOW)) ?
                      SW'(slot_sum - (SW+1)'(MAX_WINDOW)) : SW'(slot_sum);

    assign base_slot_next = (base_slot_reg == SW'(MAX_WINDOW - 1)) ? '0 : base_slot_reg + 1'b1;
    assign ptr_next       = (ptr_reg == SW'(MAX_WINDOW - 1)) ? '0 : ptr_reg + 1'b1;

    assign slot_live = in_use_reg[ptr_reg] && !acked_reg[ptr_reg];
    assign age_inc   = (age_rd == AGE_MAX) ? AGE_MAX : age_rd + 8'd1;

    always_comb begin
        stat              = '0;
        stat.accept       = accept;
        stat.op           = op_t'(s_data.op);
        stat.window_empty = (cnt_reg == '0);
        stat.ack_mark     = ack_hit && in_use_reg[slot_sel] && !acked_reg[slot_sel];
        stat.slide_go     = (cnt_reg != '0) && in_use_reg[base_slot_reg] &&
                            acked_reg[base_slot_reg];
        stat.timed_out    = slot_live && (age_inc >= timeout_reg);
        stat.scan_last    = (CW'(idx_reg + 1'b1) == cnt_reg);
        stat.out_free     = out_free;
    end

    // ---------------- slot storage ----------------
    assign buf_wr_en   = ctrl.load_send && send_ok;
    assign age_wr_en   = buf_wr_en || (ctrl.age_upd && slot_live);
    assign age_wr_addr = buf_wr_en ? slot_sel : ptr_reg;
    assign age_wr_data = (buf_wr_en || stat.timed_out) ? 8'd0 : age_inc;

    srsw_slot_ram #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (HANDLE_BITS),
        .AW    (SW)
    ) u_buf_ram (
        .aclk    (aclk),
        .wr_en   (buf_wr_en),
        .wr_addr (slot_sel),
        .wr_data (hnd_reg),
        .rd_addr (ptr_reg),
        .rd_data (buf_rd)
    );

    srsw_slot_ram #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (8),
        .AW    (SW)
    ) u_age_ram (
        .aclk    (aclk),
        .wr_en   (age_wr_en),
        .wr_addr (age_wr_addr),
        .wr_data (age_wr_data),
        .rd_addr (ptr_reg),
        .rd_data (age_rd)
    );

    // ---------------- control state ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_size_reg  <= WIN_LIMIT_RESET;
            timeout_reg   <= TIMEOUT_TICKS_RESET;
            base_reg      <= '0;
            next_reg      <= '0;
            cnt_reg       <= '0;
            base_slot_reg <= '0;
            in_use_reg    <= '0;
            acked_reg     <= '0;
            finished_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (reg_idx_t'(paddr[2]))
                    REG_WIN_LIMIT:     win_size_reg <= pwdata[3:0];
                    REG_TIMEOUT_TICKS: timeout_reg  <= pwdata[7:0];
                    default:           win_size_reg <= win_size_reg;
                endcase
            end
            if (accept && (op_t'(s_data.op) == OP_END)) begin
                finished_reg <= 1'b1;
            end
            if (buf_wr_en) begin
                in_use_reg[slot_sel] <= 1'b1;
                acked_reg[slot_sel]  <= 1'b0;
                next_reg             <= alu_res;
                cnt_reg              <= cnt_reg + 1'b1;
            end
            if (ctrl.mark_ack) begin
                acked_reg[slot_sel] <= 1'b1;
            end
            if (ctrl.slide) begin
                in_use_reg[base_slot_reg] <= 1'b0;
                acked_reg[base_slot_reg]  <= 1'b0;
                base_slot_reg             <= base_slot_next;
                base_reg                  <= alu_res;
                cnt_reg                   <= cnt_reg - 1'b1;
            end
            if (ctrl.load_send || ctrl.load_retx || ctrl.load_status) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- request capture, scan pointer, result register ----------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            hnd_reg <= HANDLE_BITS'(s_data.handle);
            ack_reg <= SEQ_BITS'(s_data.ack_seq);
        end
        if (ctrl.scan_start) begin
            ptr_reg <= base_slot_reg;
            idx_reg <= '0;
        end else if (ctrl.advance) begin
            ptr_reg <= ptr_next;
            idx_reg <= idx_reg + 1'b1;
        end
        if (ctrl.load_send) begin
            out_reg.kind          <= send_ok ? KIND_NEW : KIND_REFUSED;
            out_reg.seq           <= send_ok ? 16'(next_reg) : 16'd0;
            out_reg.buffer_handle <= 16'(hnd_reg);
            out_reg.base_seq      <= 16'(base_reg);
            out_reg.outstanding   <= send_ok ? 4'(cnt_reg + 1'b1) : 4'(cnt_reg);
            out_reg.done_res      <= send_ok ? 1'b0 : done_now;
            out_reg.last          <= 1'b1;
        end else if (ctrl.load_retx) begin
            out_reg.kind          <= KIND_RETX;
            out_reg.seq           <= 16'(alu_res);
            out_reg.buffer_handle <= 16'(buf_rd);
            out_reg.base_seq      <= 16'(base_reg);
            out_reg.outstanding   <= 4'(cnt_reg);
            out_reg.done_res      <= done_now;
            out_reg.last          <= 1'b0;
        end else if (ctrl.load_status) begin
            out_reg.kind          <= KIND_STATUS;
            out_reg.seq           <= 16'd0;
            out_reg.buffer_handle <= 16'd0;
            out_reg.base_seq      <= 16'(base_reg);
            out_reg.outstanding   <= 4'(cnt_reg);
            out_reg.done_res      <= done_now;
            out_reg.last          <= 1'b1;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // ---------------- assertions ----------------
    a_next_tracks_base : assert property (@(posedge aclk) disable iff (!aresetn)
        (next_reg - base_reg) == SEQ_BITS'(cnt_reg))
        else $error("next sequence out of step with base and fill count");

    a_busy_after_accept : assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("new request taken while the previous one is in progress");

    a_partial_blocks : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last) |-> !s_ready)
        else $error("ready while a non-final result is still pending");

    a_fill_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        buf_wr_en |-> (cnt_reg < CW'(WIN_CAP)))
        else $error("send stored beyond the window cap");

endmodule
